FILE: src/cpt_pkg.sv
package cpt_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int OWNER_W = 32;
   localparam int CAPS_W = 32;
   localparam int SLOT_W = OWNER_W + CAPS_W;

   typedef enum logic [1:0] {
      OP_GRANT  = 2'd0,
      OP_REVOKE = 2'd1,
      OP_CHECK  = 2'd2,
      OP_GET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND  = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [IDX_W-1:0]  addr;
      logic [SLOT_W-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic              ok;
      status_type        status;
      logic [CAPS_W-1:0] caps;
   } result_type;

endpackage

FILE: src/cpt_ram.sv
module cpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cpt_seq.sv
module cpt_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [cpt_pkg::OWNER_W-1:0]         req_owner_id,
   input  logic [cpt_pkg::CAPS_W-1:0]          req_cap_mask,
   output cpt_pkg::ram_req_type                ram_req,
   input  logic [cpt_pkg::SLOT_W-1:0]          ram_rd_data,
   input  logic                                out_free,
   output cpt_pkg::result_type                 result
);

   cpt_pkg::state_type                 state_ff, state_in;
   cpt_pkg::op_type                    op_ff, op_in;
   logic [cpt_pkg::OWNER_W-1:0]        owner_ff, owner_in;
   logic [cpt_pkg::CAPS_W-1:0]         mask_ff, mask_in;
   logic [cpt_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [cpt_pkg::CNT_W-1:0]          scan_ff, scan_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic [cpt_pkg::IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                               hit_ff, hit_in;
   logic [cpt_pkg::IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic [cpt_pkg::CAPS_W-1:0]         caps_ff, caps_in;
   logic                               owner_match;
   logic                               table_full;

   // the owner compare on the slot read back, used by the scan
   assign owner_match = (ram_rd_data[cpt_pkg::SLOT_W-1:cpt_pkg::CAPS_W] == owner_ff);
   assign table_full  = (count_ff == cpt_pkg::CNT_W'(cpt_pkg::TABLE_ENTRIES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cpt_pkg::S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
      op_ff      <= op_in;
      owner_ff   <= owner_in;
      mask_ff    <= mask_in;
      scan_ff    <= scan_in;
      rd_idx_ff  <= rd_idx_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      caps_ff    <= caps_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      owner_in   = owner_ff;
      mask_in    = mask_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      caps_in    = caps_ff;
      req_ready  = 1'b0;
      ram_req    = '0;
      result     = '0;
      result.status = cpt_pkg::ST_ABSENT;

      unique case (state_ff)
         cpt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = cpt_pkg::op_type'(req_opcode);
               owner_in = req_owner_id;
               mask_in  = req_cap_mask;
               scan_in  = '0;
               hit_in   = 1'b0;
               state_in = (count_ff == '0) ? cpt_pkg::S_DECIDE : cpt_pkg::S_SCAN;
            end
         end

         cpt_pkg::S_SCAN: begin
            priority if (rd_vld_ff && owner_match) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               caps_in    = ram_rd_data[cpt_pkg::CAPS_W-1:0];
               state_in   = cpt_pkg::S_DECIDE;
            end else if (scan_ff == count_ff) begin
               if (!rd_vld_ff) begin
                  state_in = cpt_pkg::S_DECIDE;
               end
            end else begin
               ram_req.rd_en = 1'b1;
               ram_req.addr  = scan_ff[cpt_pkg::IDX_W-1:0];
               rd_vld_in     = 1'b1;
               rd_idx_in     = scan_ff[cpt_pkg::IDX_W-1:0];
               scan_in       = scan_ff + cpt_pkg::CNT_W'(1);
            end
         end

         cpt_pkg::S_DECIDE: begin
            if (out_free) begin
               result.valid = 1'b1;
               state_in     = cpt_pkg::S_IDLE;
               if (hit_ff) begin
                  result.status = cpt_pkg::ST_FOUND;
                  result.ok     = 1'b1;
                  result.caps   = caps_ff;
                  ram_req.addr  = hit_idx_ff;
                  unique case (op_ff)
                     cpt_pkg::OP_GRANT: begin
                        result.caps     = caps_ff | mask_ff;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_data = {owner_ff, caps_ff | mask_ff};
                     end
                     cpt_pkg::OP_REVOKE: begin
                        result.caps     = caps_ff & ~mask_ff;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_data = {owner_ff, caps_ff & ~mask_ff};
                     end
                     cpt_pkg::OP_CHECK: begin
                        result.ok = ((caps_ff & mask_ff) == mask_ff);
                     end
                     cpt_pkg::OP_GET: begin
                        result.ok = 1'b1;
                     end
                     default: begin
                        result.ok = 1'b1;
                     end
                  endcase
               end else if (op_ff == cpt_pkg::OP_GRANT) begin
                  if (table_full) begin
                     result.status = cpt_pkg::ST_FULL;
                  end else begin
                     // claim the next unused slot
                     result.status   = cpt_pkg::ST_FOUND;
                     result.ok       = 1'b1;
                     result.caps     = mask_ff;
                     ram_req.wr_en   = 1'b1;
                     ram_req.addr    = count_ff[cpt_pkg::IDX_W-1:0];
                     ram_req.wr_data = {owner_ff, mask_ff};
                     count_in        = count_ff + cpt_pkg::CNT_W'(1);
                  end
               end
            end
         end

         default: begin
            state_in = cpt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: src/capability_permission_table_unit.sv
// channel  | direction | handshake             | word
// req      | in        | req_tvalid/req_tready | opcode, owner_id, cap_mask
// rsp      | out       | rsp_tvalid/rsp_tready | ok, status, caps_value
//
// a request is decided after a scan over the slots in use, up to TABLE_ENTRIES of them,
// that stops at the first owner match; the next request is taken once the unit is back in idle
// the scan reads one slot a cycle through the single port of the slot memory
// slots fill from the bottom and are never freed, so a fill count replaces valid bits
// reset empties the table at once; no clearing pass
// a held response stalls the next one only at its final step
module capability_permission_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // opcode[1:0], owner_id[33:2], cap_mask[65:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // ok[0], status[2:1], caps_value[34:3]
);

   cpt_pkg::ram_req_type             ram_req;
   logic [cpt_pkg::SLOT_W-1:0]       ram_rd_data;
   cpt_pkg::result_type              result;
   logic                             out_free;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;
   logic [cpt_pkg::CAPS_W-1:0]       rsp_caps_ff, rsp_caps_in;

   cpt_ram #(
      .WIDTH (cpt_pkg::SLOT_W),
      .DEPTH (cpt_pkg::TABLE_ENTRIES)
   ) u_slots (
      .clock   (clock),
      .rd_en   (ram_req.rd_en),
      .wr_en   (ram_req.wr_en),
      .addr    (ram_req.addr),
      .wr_data (ram_req.wr_data),
      .rd_data (ram_rd_data)
   );

   cpt_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_opcode   (req_tdata[1:0]),
      .req_owner_id (req_tdata[33:2]),
      .req_cap_mask (req_tdata[65:34]),
      .ram_req      (ram_req),
      .ram_rd_data  (ram_rd_data),
      .out_free     (out_free),
      .result       (result)
   );

   assign out_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_caps_in   = rsp_caps_ff;
      if (out_free) begin
         rsp_vld_in = result.valid;
      end
      if (result.valid) begin
         rsp_ok_in     = result.ok;
         rsp_status_in = result.status;
         rsp_caps_in   = result.caps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_caps_ff   <= rsp_caps_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_caps_ff, rsp_status_ff, rsp_ok_ff};

endmodule

FILE: tb/perm_table_checker.sv
module perm_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          due_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                       ok;
      cpt_pkg::status_type        status;
      logic [cpt_pkg::CAPS_W-1:0] caps;
   } perm_reply_type;

   logic [cpt_pkg::OWNER_W-1:0] owner_of_slot [cpt_pkg::TABLE_ENTRIES];
   logic [cpt_pkg::CAPS_W-1:0]  caps_of_slot [cpt_pkg::TABLE_ENTRIES];
   int                          slots_used = 0;
   perm_reply_type              replies_due [$];

   // slots fill from the bottom and are never released
   function automatic perm_reply_type apply_request(input cpt_pkg::op_type op,
                                                    input logic [cpt_pkg::OWNER_W-1:0] owner,
                                                    input logic [cpt_pkg::CAPS_W-1:0] mask);
      perm_reply_type r;
      int             hit;
      r.ok = 1'b0;
      r.status = cpt_pkg::ST_ABSENT;
      r.caps = '0;
      hit = -1;
      for (int i = 0; i < slots_used; i++)
         if (hit < 0 && owner_of_slot[i] == owner)
            hit = i;
      if (op == cpt_pkg::OP_GRANT && hit < 0) begin
         if (slots_used == cpt_pkg::TABLE_ENTRIES) begin
            r.status = cpt_pkg::ST_FULL;
         end else begin
            hit = slots_used;
            owner_of_slot[hit] = owner;
            caps_of_slot[hit] = '0;
            slots_used++;
         end
      end
      if (hit >= 0) begin
         r.status = cpt_pkg::ST_FOUND;
         case (op)
            cpt_pkg::OP_GRANT: begin
               caps_of_slot[hit] = caps_of_slot[hit] | mask;
               r.ok = 1'b1;
            end
            cpt_pkg::OP_REVOKE: begin
               caps_of_slot[hit] = caps_of_slot[hit] & ~mask;
               r.ok = 1'b1;
            end
            cpt_pkg::OP_CHECK: r.ok = ((caps_of_slot[hit] & mask) == mask);
            default: r.ok = 1'b1;
         endcase
         r.caps = caps_of_slot[hit];
      end
      return r;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want_v,
                                         input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      perm_reply_type want;
      if (reset) begin
         replies_due.delete();
         slots_used = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: response with none expected, expected none actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               compare_field("ok", 32'(want.ok), 32'(rsp_tdata[0]));
               compare_field("status", 32'(want.status), 32'(rsp_tdata[2:1]));
               compare_field("caps_value", want.caps, rsp_tdata[34:3]);
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(apply_request(cpt_pkg::op_type'(req_tdata[1:0]),
                                                req_tdata[33:2], req_tdata[65:34]));
      end
      due_count = replies_due.size();
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SIZE    = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = cpt_pkg::TABLE_ENTRIES + 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // opcode[1:0], owner_id[33:2], cap_mask[65:34]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // ok[0], status[2:1], caps_value[34:3]

   int          fail_count;
   int          due_count;
   int          tx_idle_pct = 36;
   int          rx_idle_pct = 61;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   logic [31:0] owner_pool [POOL_SIZE];

   always #10 clock = ~clock;

   capability_permission_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   perm_table_checker perm_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .due_count  (due_count)
   );

   // receiver, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_word(input cpt_pkg::op_type op, input logic [31:0] owner,
                            input logic [31:0] mask);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= {8'($urandom), $urandom, $urandom};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, mask, owner, op};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] pick_mask();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return 32'd1 << $urandom_range(31);
         3: return $urandom & $urandom;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(input int fresh_pct);
      logic [31:0] owner;
      if ($urandom_range(99) < fresh_pct)
         owner = $urandom;
      else
         owner = owner_pool[$urandom_range(POOL_SIZE - 1)];
      send_word(cpt_pkg::op_type'($urandom_range(3)), owner, pick_mask());
   endtask

   initial begin
      logic [31:0] fill_base;
      for (int i = 0; i < POOL_SIZE; i++)
         owner_pool[i] = $urandom;
      owner_pool[0] = '0;
      owner_pool[1] = '1;
      owner_pool[2] = 32'h1234_5678;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // empty table: absent owners, then allocation, empty masks and extremes
      send_word(cpt_pkg::OP_GET,    32'h0000_0000, 32'hFFFF_FFFF);
      send_word(cpt_pkg::OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000);
      send_word(cpt_pkg::OP_REVOKE, 32'h0000_0005, 32'hFFFF_FFFF);
      send_word(cpt_pkg::OP_GRANT,  32'h0000_0000, 32'h0000_0000);
      send_word(cpt_pkg::OP_CHECK,  32'h0000_0000, 32'h0000_0000);
      send_word(cpt_pkg::OP_CHECK,  32'h0000_0000, 32'h0000_0001);
      send_word(cpt_pkg::OP_GRANT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(cpt_pkg::OP_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(cpt_pkg::OP_REVOKE, 32'hFFFF_FFFF, 32'h0000_FFFF);
      send_word(cpt_pkg::OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(cpt_pkg::OP_CHECK,  32'hFFFF_FFFF, 32'hFFFF_0001);
      send_word(cpt_pkg::OP_GRANT,  32'h0000_0000, 32'h8000_0001);
      send_word(cpt_pkg::OP_GRANT,  32'h0000_0000, 32'h8000_0001);
      send_word(cpt_pkg::OP_REVOKE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(cpt_pkg::OP_GET,    32'h0000_0000, 32'h0000_0000);
      send_word(cpt_pkg::OP_GRANT,  32'h1234_5678, 32'hA5A5_A5A5);
      send_word(cpt_pkg::OP_REVOKE, 32'h1234_5678, 32'h0000_0000);
      send_word(cpt_pkg::OP_CHECK,  32'h1234_5678, 32'hA5A5_A5A5);
      send_word(cpt_pkg::OP_CHECK,  32'h1234_5678, 32'h5A5A_5A5A);

      repeat (260) send_random(15);
      tx_idle_pct = 61;
      rx_idle_pct = 36;
      repeat (260) send_random(15);

      // fill the table to overflow while the receiver holds off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_toggle = ~hold_toggle;
      fill_base = $urandom;
      for (int i = 0; i < cpt_pkg::TABLE_ENTRIES; i++)
         send_word(cpt_pkg::OP_GRANT, fill_base + i, pick_mask());
      repeat (60) send_random(50);

      @(negedge clock) req_tvalid <= 1'b0;
      wait (due_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_count == 0)
         $display("capability_permission_table_unit test passed");
      else
         $display("capability_permission_table_unit test failed");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("capability_permission_table_unit test failed");
      $finish;
   end

endmodule
